// ===== rtl/rtkl_pkg.sv =====
`timescale 1ns / 1ps
package rtkl_pkg;
  localparam int unsigned Groups     = 8;
  localparam int unsigned EntryDepth = 256;
  localparam int unsigned AuxBytes   = 4096;
  localparam int unsigned AuxWords   = AuxBytes / 8;
  localparam int unsigned GrpW  = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned SlotW = $clog2(EntryDepth);
  localparam int unsigned AuxAW = $clog2(AuxWords);
  localparam int unsigned AuxBW = $clog2(AuxBytes);

  localparam logic [31:0] VersionOk = 32'h0000_0001;
  localparam logic [31:0] MagicOk   = 32'h0c03_30db;
  localparam logic [15:0] SlaveLow  = 16'd3;
  localparam logic [15:0] SlaveHigh = 16'd5;

  localparam logic [1:0] OpLoadGroup = 2'd0;
  localparam logic [1:0] OpLoadEntry = 2'd1;
  localparam logic [1:0] OpLoadAux   = 2'd2;
  localparam logic [1:0] OpQuery     = 2'd3;

  localparam logic [0:0] RegVersion = 1'b0;
  localparam logic [0:0] RegMagic   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_GRP, S_SREQ, S_SCHK, S_SUM, S_AREQ, S_AWAIT, S_ADAT, S_ADONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;     // capture input beat
    logic grp_next;
    logic slot_init;   // start slot walk in current group
    logic slot_next;
    logic slot_rd;     // slot read cycle; the datapath does not use it
    logic hit_save;
    logic sum_load;    // load summary into output
    logic aux_init;
    logic aux_rd;
    logic aux_save;    // latch aux read word
    logic aux_byte;    // merge one byte
    logic dat_load;    // load data word into output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic hdr_ok;
    logic grp_done;
    logic grp_valid;
    logic slot_done;
    logic key_match;
    logic copy_zero;
    logic word_full;   // current word has all its bytes or holds the last byte
    logic copy_done;   // all bytes merged
  } sts_t;

  function automatic logic [63:0] mask_key(input logic [63:0] k);
    logic [63:0] r;
    logic        stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction
endpackage

// ===== rtl/resource_table_key_lookup.sv =====
`timescale 1ns / 1ps
// resource table key lookup
// input channel: in_valid / in_stall, one beat per op (load group, load
// entry, load aux word, query); loads give no result
// output channel: out_valid / out_stall; a query gives one summary beat,
// then ceil(xfer_len/8) aux data beats, the final one marked by out_last
// config: apb-style port, header_version at 0x0, header_magic at 0x4;
// a bad header makes every query miss
// sequence: a load is taken in S_IDLE and ends in S_GRP; a query visits
// S_GRP per group, S_SREQ then S_SCHK per scanned slot (slot memory read
// then key compare) and S_SREQ once more to close each valid group, S_SUM
// for the summary beat, then S_AREQ, S_AWAIT and S_ADAT per aux byte
// (read, latch, merge) plus S_ADONE per data word; groups may overlap,
// and a query also waits out any output stall
// one beat is worked at a time; a new beat is taken once the last result
// is loaded into the output register
// reset (synchronous, rst_n low) clears the control state, the header
// registers and the group table; slot and aux memories are not cleared
// a stall on a valid output beat holds the output register and keeps the walk waiting in S_SUM or S_ADONE
module resource_table_key_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [8:0]  in_index,
  input  logic [15:0] in_slave_id,
  input  logic [7:0]  in_first_slot,
  input  logic [15:0] in_entry_count,
  input  logic [15:0] in_data_base,
  input  logic [63:0] in_key,
  input  logic [31:0] in_target_addr,
  input  logic [15:0] in_length,
  input  logic [15:0] in_aux_offset,
  input  logic [63:0] in_aux_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_data,
  output logic        out_found,
  output logic [31:0] out_found_addr,
  output logic [15:0] out_found_len,
  output logic        out_aux_ok,
  output logic [7:0]  out_xfer_len,
  output logic [63:0] out_data_word,
  output logic        out_last
);
  import rtkl_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        out_busy;
  logic [31:0] cfg_version_r;
  logic [31:0] cfg_magic_r;
  logic        cfg_wr;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_version_r <= '0;
      cfg_magic_r   <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegVersion) cfg_version_r <= pwdata;
      else cfg_magic_r <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegMagic) prdata = cfg_magic_r;
      else prdata = cfg_version_r;
    end
  end

  rtkl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtkl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .hdr_version    (cfg_version_r),
    .hdr_magic      (cfg_magic_r),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_slave_id    (in_slave_id),
    .in_first_slot  (in_first_slot),
    .in_entry_count (in_entry_count),
    .in_data_base   (in_data_base),
    .in_key         (in_key),
    .in_target_addr (in_target_addr),
    .in_length      (in_length),
    .in_aux_offset  (in_aux_offset),
    .in_aux_word    (in_aux_word),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_busy       (out_busy),
    .out_is_data    (out_is_data),
    .out_found      (out_found),
    .out_found_addr (out_found_addr),
    .out_found_len  (out_found_len),
    .out_aux_ok     (out_aux_ok),
    .out_xfer_len   (out_xfer_len),
    .out_data_word  (out_data_word),
    .out_last       (out_last)
  );
endmodule

// ===== rtl/rtkl_ram.sv =====
`timescale 1ns / 1ps
module rtkl_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rtkl_ctrl.sv =====
`timescale 1ns / 1ps
module rtkl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_busy,
  input  rtkl_pkg::sts_t sts,
  output rtkl_pkg::cmd_t cmd
);
  import rtkl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt = S_GRP;
        end
      end
      S_GRP: begin
        if (!sts.is_query) begin
          state_nxt = S_IDLE;
        end else if (!sts.hdr_ok || sts.grp_done) begin
          state_nxt = S_SUM;
        end else if (sts.grp_valid) begin
          cmd.slot_init = 1'b1;
          state_nxt = S_SREQ;
        end else begin
          cmd.grp_next = 1'b1;
        end
      end
      S_SREQ: begin
        if (sts.slot_done) begin
          cmd.grp_next = 1'b1;
          state_nxt = S_GRP;
        end else begin
          cmd.slot_rd = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts.key_match) begin
          cmd.hit_save = 1'b1;
          state_nxt = S_SUM;
        end else begin
          cmd.slot_next = 1'b1;
          state_nxt = S_SREQ;
        end
      end
      S_SUM: begin
        if (!out_busy) begin
          cmd.sum_load = 1'b1;
          cmd.aux_init = 1'b1;
          state_nxt = sts.copy_zero ? S_IDLE : S_AREQ;
        end
      end
      S_AREQ: begin
        cmd.aux_rd = 1'b1;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        cmd.aux_save = 1'b1;
        state_nxt = S_ADAT;
      end
      S_ADAT: begin
        cmd.aux_byte = 1'b1;
        if (sts.word_full) state_nxt = S_ADONE;
        else state_nxt = S_AREQ;
      end
      S_ADONE: begin
        if (!out_busy) begin
          cmd.dat_load = 1'b1;
          state_nxt = sts.copy_done ? S_IDLE : S_AREQ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/rtkl_dp.sv =====
`timescale 1ns / 1ps
module rtkl_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  rtkl_pkg::cmd_t cmd,
  output rtkl_pkg::sts_t sts,
  input  logic [31:0]    hdr_version,
  input  logic [31:0]    hdr_magic,
  input  logic [1:0]     in_op,
  input  logic [8:0]     in_index,
  input  logic [15:0]    in_slave_id,
  input  logic [7:0]     in_first_slot,
  input  logic [15:0]    in_entry_count,
  input  logic [15:0]    in_data_base,
  input  logic [63:0]    in_key,
  input  logic [31:0]    in_target_addr,
  input  logic [15:0]    in_length,
  input  logic [15:0]    in_aux_offset,
  input  logic [63:0]    in_aux_word,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           out_busy,
  output logic           out_is_data,
  output logic           out_found,
  output logic [31:0]    out_found_addr,
  output logic [15:0]    out_found_len,
  output logic           out_aux_ok,
  output logic [7:0]     out_xfer_len,
  output logic [63:0]    out_data_word,
  output logic           out_last
);
  import rtkl_pkg::*;

  localparam int unsigned SlotEntW = 64 + 32 + 16 + 16;

  // group table in flops, cleared at reset
  logic [15:0] grp_slave_r [Groups];
  logic [7:0]  grp_start_r [Groups];
  logic [15:0] grp_size_r  [Groups];
  logic [15:0] grp_base_r  [Groups];

  logic [1:0]  op_r;
  logic [63:0] qkey_r;
  logic [7:0]  cap_r;
  logic [GrpW:0]  gi_r;
  logic [16:0]    si_r;      // offset within group
  logic [SlotW:0] slot_r;    // absolute slot
  logic [31:0] haddr_r;
  logic [15:0] hlen_r;
  logic [15:0] hoff_r;
  logic [15:0] hbase_r;
  logic        hit_r;
  logic [7:0]  clen_r;
  logic [7:0]  k_r;          // bytes merged
  logic [AuxBW-1:0] baddr_r;
  logic [63:0] aword_r;
  logic [63:0] acc_r;

  logic [SlotEntW-1:0] slot_q;
  logic [63:0]         aux_q;
  logic [GrpW-1:0]     gsel;

  logic in_load_grp, in_load_ent, in_load_aux;
  assign in_load_grp = cmd.take_in && in_op == OpLoadGroup && {23'd0, in_index} < 32'(Groups);
  assign in_load_ent = cmd.take_in && in_op == OpLoadEntry
                       && {23'd0, in_index} < 32'(EntryDepth);
  assign in_load_aux = cmd.take_in && in_op == OpLoadAux && {23'd0, in_index} < 32'(AuxWords);

  rtkl_ram #(.Width(SlotEntW), .Depth(EntryDepth)) u_slot_ram (
    .clk   (clk),
    .we    (in_load_ent),
    .waddr (in_index[SlotW-1:0]),
    .wdata ({in_key, in_target_addr, in_length, in_aux_offset}),
    .raddr (slot_r[SlotW-1:0]),
    .rdata (slot_q)
  );

  rtkl_ram #(.Width(64), .Depth(AuxWords)) u_aux_ram (
    .clk   (clk),
    .we    (in_load_aux),
    .waddr (in_index[AuxAW-1:0]),
    .wdata (in_aux_word),
    .raddr (baddr_r[AuxBW-1:3]),
    .rdata (aux_q)
  );

  assign gsel = gi_r[GrpW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < Groups; g++) begin
        grp_slave_r[g] <= '0;
        grp_start_r[g] <= '0;
        grp_size_r[g]  <= '0;
        grp_base_r[g]  <= '0;
      end
    end else if (in_load_grp) begin
      grp_slave_r[in_index[GrpW-1:0]] <= in_slave_id;
      grp_start_r[in_index[GrpW-1:0]] <= in_first_slot;
      grp_size_r[in_index[GrpW-1:0]]  <= in_entry_count;
      grp_base_r[in_index[GrpW-1:0]]  <= in_data_base;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_r   <= in_op;
      qkey_r <= mask_key(in_key);
      cap_r  <= (in_length > 16'd255) ? 8'd255 : in_length[7:0];
      gi_r   <= '0;
      hit_r  <= 1'b0;
    end
    if (cmd.grp_next) gi_r <= gi_r + 1'b1;
    if (cmd.slot_init) begin
      si_r   <= '0;
      slot_r <= {1'b0, grp_start_r[gsel]};
    end
    if (cmd.slot_next) begin
      si_r   <= si_r + 1'b1;
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.hit_save) begin
      hit_r   <= 1'b1;
      haddr_r <= slot_q[63:32];
      hlen_r  <= slot_q[31:16];
      hoff_r  <= slot_q[15:0];
      hbase_r <= grp_base_r[gsel];
    end
    if (cmd.sum_load) begin
      clen_r <= sts.copy_zero ? 8'd0
              : ((cap_r < hlen_r[7:0] || hlen_r[15:8] != 8'd0) ? cap_r : hlen_r[7:0]);
    end
    if (cmd.aux_init) begin
      k_r     <= '0;
      baddr_r <= AuxBW'(hbase_r + hoff_r);
      acc_r   <= '0;
    end
    if (cmd.aux_save) aword_r <= aux_q;
    if (cmd.aux_byte) begin
      acc_r[8*k_r[2:0] +: 8] <= aword_r[8*baddr_r[2:0] +: 8];
      k_r     <= k_r + 1'b1;
      baddr_r <= baddr_r + 1'b1;
    end
    if (cmd.dat_load) acc_r <= '0;
  end

  // status
  logic        gvalid;
  logic [8:0]  kn;
  assign gvalid = grp_slave_r[gsel] >= SlaveLow && grp_slave_r[gsel] <= SlaveHigh;
  assign kn = {1'b0, k_r} + 9'd1;
  always_comb begin
    sts.is_query  = op_r == OpQuery;
    sts.hdr_ok    = hdr_version == VersionOk && hdr_magic == MagicOk;
    sts.grp_done  = gi_r == (GrpW+1)'(Groups);
    sts.grp_valid = gvalid;
    sts.slot_done = si_r >= {1'b0, grp_size_r[gsel]} || slot_r >= (SlotW+1)'(EntryDepth);
    sts.key_match = slot_q[127:64] == qkey_r;
    sts.copy_zero = !hit_r || hlen_r == 16'd0 || cap_r == 8'd0;
    sts.word_full = kn[2:0] == 3'd0 || kn == {1'b0, clen_r};
    sts.copy_done = k_r == clen_r;
  end

  // output register
  logic sum_zero;
  assign sum_zero = sts.copy_zero;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.sum_load || cmd.dat_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      out_is_data    <= 1'b0;
      out_found      <= hit_r;
      out_found_addr <= hit_r ? haddr_r : 32'd0;
      out_found_len  <= hit_r ? hlen_r : 16'd0;
      out_aux_ok     <= hit_r && hlen_r != 16'd0;
      out_xfer_len   <= sum_zero ? 8'd0
                      : ((cap_r < hlen_r[7:0] || hlen_r[15:8] != 8'd0) ? cap_r : hlen_r[7:0]);
      out_data_word  <= '0;
      out_last       <= sum_zero;
    end else if (cmd.dat_load) begin
      out_is_data    <= 1'b1;
      out_found      <= 1'b0;
      out_found_addr <= '0;
      out_found_len  <= '0;
      out_aux_ok     <= 1'b0;
      out_xfer_len   <= '0;
      out_data_word  <= acc_r;
      out_last       <= k_r == clen_r;
    end
  end
  assign out_busy = out_valid && out_stall;
endmodule

// ===== rtl/rtkl_checker.sv =====
`timescale 1ns / 1ps
module rtkl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_is_data,
  input logic        out_found,
  input logic        out_aux_ok,
  input logic [7:0]  out_xfer_len,
  input logic [63:0] out_data_word,
  input logic        out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_word) && $stable(out_last))
    else $error("stalled beat changed");
  a_auxok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data && out_aux_ok |-> out_found)
    else $error("aux_ok without found");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data && !out_aux_ok |-> out_last && out_xfer_len == 8'd0)
    else $error("miss not final");
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_data |-> !out_found && out_xfer_len == 8'd0)
    else $error("data beat with summary fields");
endmodule

bind resource_table_key_lookup rtkl_checker u_rtkl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_is_data   (out_is_data),
  .out_found     (out_found),
  .out_aux_ok    (out_aux_ok),
  .out_xfer_len  (out_xfer_len),
  .out_data_word (out_data_word),
  .out_last      (out_last)
);
